>>> rtl/dqp_pkg.sv
// Package for the DNS query question parser.
// Holds the result record, status codes and header byte offsets.
// No dependencies.
package dqp_pkg;

   localparam int HEADER_BYTES = 12;
   localparam int MAX_LABEL    = 64;

   localparam logic [3:0] HDR_ID_HI    = 4'd0;
   localparam logic [3:0] HDR_ID_LO    = 4'd1;
   localparam logic [3:0] HDR_COUNT_HI = 4'd4;
   localparam logic [3:0] HDR_COUNT_LO = 4'd5;

   localparam logic [2:0] TAIL_TYPE_HI  = 3'd0;
   localparam logic [2:0] TAIL_TYPE_LO  = 3'd1;
   localparam logic [2:0] TAIL_CLASS_HI = 3'd2;
   localparam logic [2:0] TAIL_CLASS_LO = 3'd3;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_SHORT  = 3'd1;
   localparam logic [2:0] ST_COUNT  = 3'd2;
   localparam logic [2:0] ST_NOTERM = 3'd3;
   localparam logic [2:0] ST_LONG   = 3'd4;
   localparam logic [2:0] ST_TRUNC  = 3'd5;
   localparam logic [2:0] ST_OVER   = 3'd6;
   localparam logic [2:0] ST_TAIL   = 3'd7;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   typedef struct packed {
      logic        is_summary;
      logic [7:0]  name_char;
      logic [2:0]  status;
      logic [15:0] query_id;
      logic [15:0] query_type;
      logic [15:0] query_class;
      logic [7:0]  name_length;
   } rsp_type;

endpackage

>>> rtl/dqp_out_queue.sv
// Two-entry result queue between the parser and the result channel.
// Depends on dqp_pkg for the result record.
module dqp_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dqp_pkg::rsp_type push_data,
   output logic             full,
   output logic             out_valid,
   input  logic             out_stall,
   output dqp_pkg::rsp_type out_data
);
   import dqp_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = (count_ff != 2'd0) && !out_stall;
   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/dns_query_question_parser_core.sv
// Top level of the DNS query question parser.
// Depends on dqp_pkg and dqp_out_queue.
//
// Usage:
// The request channel carries one packet byte per transfer, with
// req_end_of_packet high on the last byte of a packet. The parser emits
// one result transfer per name character (lowercased, dots between labels)
// and one summary transfer on the last byte, which carries the status,
// transaction ID, question type and class and the name length.
// A byte is handled in the cycle it is accepted; its result is held in a
// two-entry queue and is offered on the result channel from there.
// The block takes one byte every cycle as long as the result channel does
// not stall; the queue stalls the request side only once it holds two
// results that have not been taken. Bytes that produce no result still
// need a free queue slot to be accepted.
// Reset (synchronous, active high) empties the queue and returns the
// parser to the start of a packet header. After each summary the parser
// returns to that same state on its own.
module dns_query_question_parser_core #(
   parameter int NAME_CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_end_of_packet,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_summary,
   output logic [7:0]  rsp_name_char,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_query_id,
   output logic [15:0] rsp_query_type,
   output logic [15:0] rsp_query_class,
   output logic [7:0]  rsp_name_length
);
   import dqp_pkg::*;

   localparam int CW = $clog2(NAME_CAPACITY);
   localparam int WW = ((CW > 7) ? CW : 7) + 1;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_LEN    = 3'd1;
   localparam logic [2:0] PH_BODY   = 3'd2;
   localparam logic [2:0] PH_TAIL   = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;
   localparam logic [2:0] PH_ERR    = 3'd5;

   logic [2:0]    phase_ff, phase_in;
   logic [3:0]    header_offset_ff, header_offset_in;
   logic [5:0]    label_left_ff, label_left_in;
   logic [CW-1:0] chars_written_ff, chars_written_in;
   logic          first_label_ff, first_label_in;
   logic [15:0]   held_id_ff, held_id_in;
   logic [15:0]   held_count_ff, held_count_in;
   logic [15:0]   held_type_ff, held_type_in;
   logic [15:0]   held_class_ff, held_class_in;
   logic [2:0]    tail_offset_ff, tail_offset_in;
   logic [2:0]    held_error_ff, held_error_in;

   logic          accept;
   logic          queue_full;
   logic          emit;
   logic          push;
   logic [WW-1:0] need;
   logic [WW-1:0] room;
   logic [15:0]   name_len_wide;
   logic [2:0]    summary_status;
   rsp_type       result;
   rsp_type       head;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept && (emit || req_end_of_packet);

   always_comb begin
      phase_in         = phase_ff;
      header_offset_in = header_offset_ff;
      label_left_in    = label_left_ff;
      chars_written_in = chars_written_ff;
      first_label_in   = first_label_ff;
      held_id_in       = held_id_ff;
      held_count_in    = held_count_ff;
      held_type_in     = held_type_ff;
      held_class_in    = held_class_ff;
      tail_offset_in   = tail_offset_ff;
      held_error_in    = held_error_ff;
      emit             = 1'b0;
      result           = '0;
      need             = WW'(req_byte_value) + WW'(!first_label_ff);
      room             = WW'(NAME_CAPACITY - 1) - WW'(chars_written_ff);

      case (phase_ff)
         PH_HEADER: begin
            case (header_offset_ff)
               HDR_ID_HI:    held_id_in[15:8]    = req_byte_value;
               HDR_ID_LO:    held_id_in[7:0]     = req_byte_value;
               HDR_COUNT_HI: held_count_in[15:8] = req_byte_value;
               HDR_COUNT_LO: held_count_in[7:0]  = req_byte_value;
               default: ;
            endcase
            header_offset_in = header_offset_ff + 4'd1;
            if (header_offset_in == 4'(HEADER_BYTES)) begin
               if (held_count_in != 16'd1) begin
                  held_error_in = ST_COUNT;
                  phase_in      = PH_ERR;
               end else begin
                  phase_in = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            if (req_byte_value == CHAR_NUL) begin
               phase_in       = PH_TAIL;
               tail_offset_in = 3'd0;
            end else if (req_byte_value >= 8'(MAX_LABEL)) begin
               held_error_in = ST_LONG;
               phase_in      = PH_ERR;
            end else begin
               // An overflowing label is still consumed; the error is
               // reported once its last byte has gone by.
               if (need > room) begin
                  held_error_in = ST_OVER;
               end else if (!first_label_ff) begin
                  emit             = 1'b1;
                  result.name_char = CHAR_DOT;
                  chars_written_in = chars_written_ff + CW'(1);
               end
               first_label_in = 1'b0;
               label_left_in  = req_byte_value[5:0];
               phase_in       = PH_BODY;
            end
         end
         PH_BODY: begin
            label_left_in = label_left_ff - 6'd1;
            if (held_error_ff == ST_OK) begin
               emit = 1'b1;
               if (req_byte_value inside {[8'h41:8'h5A]}) begin
                  result.name_char = req_byte_value + CASE_SHIFT;
               end else begin
                  result.name_char = req_byte_value;
               end
               chars_written_in = chars_written_ff + CW'(1);
            end
            if (label_left_in == 6'd0) begin
               phase_in = (held_error_ff != ST_OK) ? PH_ERR : PH_LEN;
            end
         end
         PH_TAIL: begin
            case (tail_offset_ff)
               TAIL_TYPE_HI:  held_type_in[15:8]  = req_byte_value;
               TAIL_TYPE_LO:  held_type_in[7:0]   = req_byte_value;
               TAIL_CLASS_HI: held_class_in[15:8] = req_byte_value;
               default:       held_class_in[7:0]  = req_byte_value;
            endcase
            tail_offset_in = tail_offset_ff + 3'd1;
            if (tail_offset_ff == TAIL_CLASS_LO) begin
               phase_in = PH_DONE;
            end
         end
         default: ;
      endcase

      case (phase_in)
         PH_HEADER: summary_status = ST_SHORT;
         PH_LEN:    summary_status = ST_NOTERM;
         PH_BODY:   summary_status = ST_TRUNC;
         PH_TAIL:   summary_status = ST_TAIL;
         PH_DONE:   summary_status = ST_OK;
         default:   summary_status = held_error_in;
      endcase

      name_len_wide = 16'(chars_written_in);

      if (req_end_of_packet) begin
         result.is_summary  = 1'b1;
         result.name_char   = CHAR_NUL;
         result.status      = summary_status;
         result.query_id    = held_id_in;
         result.query_type  = held_type_in;
         result.query_class = held_class_in;
         result.name_length = name_len_wide[7:0];
         phase_in         = PH_HEADER;
         header_offset_in = 4'd0;
         label_left_in    = 6'd0;
         chars_written_in = '0;
         first_label_in   = 1'b1;
         held_id_in       = 16'd0;
         held_count_in    = 16'd0;
         held_type_in     = 16'd0;
         held_class_in    = 16'd0;
         tail_offset_in   = 3'd0;
         held_error_in    = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         header_offset_ff <= 4'd0;
         label_left_ff    <= 6'd0;
         chars_written_ff <= '0;
         first_label_ff   <= 1'b1;
         held_id_ff       <= 16'd0;
         held_count_ff    <= 16'd0;
         held_type_ff     <= 16'd0;
         held_class_ff    <= 16'd0;
         tail_offset_ff   <= 3'd0;
         held_error_ff    <= ST_OK;
      end else if (accept) begin
         phase_ff         <= phase_in;
         header_offset_ff <= header_offset_in;
         label_left_ff    <= label_left_in;
         chars_written_ff <= chars_written_in;
         first_label_ff   <= first_label_in;
         held_id_ff       <= held_id_in;
         held_count_ff    <= held_count_in;
         held_type_ff     <= held_type_in;
         held_class_ff    <= held_class_in;
         tail_offset_ff   <= tail_offset_in;
         held_error_ff    <= held_error_in;
      end
   end

   dqp_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   assign rsp_is_summary  = head.is_summary;
   assign rsp_name_char   = head.name_char;
   assign rsp_status      = head.status;
   assign rsp_query_id    = head.query_id;
   assign rsp_query_type  = head.query_type;
   assign rsp_query_class = head.query_class;
   assign rsp_name_length = head.name_length;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for dns_query_question_parser_core.
// Depends on dqp_pkg for status codes, header offsets and the result record.
// Sends random DNS query packets byte by byte and predicts every result.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dqp_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 4;
   localparam int NAME_CAP     = 256;
   localparam int TAIL_BYTES   = 4;
   localparam int STAGE_BYTES  = 440;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES  = 200;
   localparam int HOLD_AFTER   = 60;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam logic [7:0] UPPER_A = "A";
   localparam logic [7:0] UPPER_Z = "Z";

   // Tracks the parse of the current packet and holds the results still owed.
   class question_scoreboard;
      typedef enum logic [2:0] {
         AT_HEADER, AT_LENGTH, IN_LABEL, AT_TAIL, QUESTION_DONE, SKIPPING
      } parse_step_type;

      parse_step_type step;
      logic [3:0]  hdr_pos;
      logic [2:0]  tail_pos;
      int          label_left;
      int          written;
      bit          on_first_label;
      logic [15:0] id, cnt, qtype, qclass;
      logic [2:0]  held_err;
      rsp_type     owed_q[$];
      int          failures;

      function new();
         failures = 0;
         clear();
      endfunction

      function void clear();
         step = AT_HEADER;
         hdr_pos = '0;
         tail_pos = '0;
         label_left = 0;
         written = 0;
         on_first_label = 1'b1;
         id = '0;
         cnt = '0;
         qtype = '0;
         qclass = '0;
         held_err = ST_OK;
      endfunction

      function int outstanding();
         return owed_q.size();
      endfunction

      function void note_byte(logic [7:0] b, logic eop);
         bit          emit;
         logic [7:0]  ch;
         int          need;
         rsp_type     r;
         emit = 1'b0;
         ch = CHAR_NUL;
         case (step)
            AT_HEADER: begin
               case (hdr_pos)
                  HDR_ID_HI:    id[15:8] = b;
                  HDR_ID_LO:    id[7:0] = b;
                  HDR_COUNT_HI: cnt[15:8] = b;
                  HDR_COUNT_LO: cnt[7:0] = b;
                  default: ;
               endcase
               hdr_pos++;
               if (hdr_pos >= HEADER_BYTES) begin
                  if (cnt != 16'd1) begin
                     held_err = ST_COUNT;
                     step = SKIPPING;
                  end else begin
                     step = AT_LENGTH;
                  end
               end
            end
            AT_LENGTH: begin
               if (b == CHAR_NUL) begin
                  step = AT_TAIL;
                  tail_pos = '0;
               end else if (b >= MAX_LABEL) begin
                  held_err = ST_LONG;
                  step = SKIPPING;
               end else begin
                  need = int'(b) + (on_first_label ? 0 : 1);
                  // An overflowing label is still consumed; the error shows once it ends.
                  if (need > NAME_CAP - 1 - written) begin
                     held_err = ST_OVER;
                  end else if (!on_first_label) begin
                     emit = 1'b1;
                     ch = CHAR_DOT;
                     written++;
                  end
                  on_first_label = 1'b0;
                  label_left = int'(b);
                  step = IN_LABEL;
               end
            end
            IN_LABEL: begin
               if (label_left > 0) label_left--;
               if (held_err == ST_OK) begin
                  ch = (b >= UPPER_A && b <= UPPER_Z) ? b + CASE_SHIFT : b;
                  emit = 1'b1;
                  written++;
               end
               if (label_left == 0) step = (held_err != ST_OK) ? SKIPPING : AT_LENGTH;
            end
            AT_TAIL: begin
               case (tail_pos)
                  TAIL_TYPE_HI:  qtype[15:8] = b;
                  TAIL_TYPE_LO:  qtype[7:0] = b;
                  TAIL_CLASS_HI: qclass[15:8] = b;
                  default:       qclass[7:0] = b;
               endcase
               tail_pos++;
               if (tail_pos >= TAIL_BYTES) step = QUESTION_DONE;
            end
            default: ;
         endcase

         r = '0;
         if (eop) begin
            r.is_summary = 1'b1;
            case (step)
               AT_HEADER:     r.status = ST_SHORT;
               AT_LENGTH:     r.status = ST_NOTERM;
               IN_LABEL:      r.status = ST_TRUNC;
               AT_TAIL:       r.status = ST_TAIL;
               QUESTION_DONE: r.status = ST_OK;
               default:       r.status = held_err;
            endcase
            r.query_id = id;
            r.query_type = qtype;
            r.query_class = qclass;
            r.name_length = 8'(written);
            owed_q.push_back(r);
            clear();
         end else if (emit) begin
            r.name_char = ch;
            owed_q.push_back(r);
         end
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_q.size() == 0) begin
            $error("result transfer with nothing expected: summary %0b char 'h%0h status %0d",
                   got.is_summary, got.name_char, got.status);
            failures++;
            return;
         end
         want = owed_q.pop_front();
         compare("is_summary", 16'(want.is_summary), 16'(got.is_summary));
         compare("name_char", 16'(want.name_char), 16'(got.name_char));
         compare("status", 16'(want.status), 16'(got.status));
         compare("query_id", want.query_id, got.query_id);
         compare("query_type", want.query_type, got.query_type);
         compare("query_class", want.query_class, got.query_class);
         compare("name_length", 16'(want.name_length), 16'(got.name_length));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = '0;
   logic        req_end_of_packet = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_summary;
   logic [7:0]  rsp_name_char;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_query_id;
   logic [15:0] rsp_query_type;
   logic [15:0] rsp_query_class;
   logic [7:0]  rsp_name_length;

   question_scoreboard board;
   logic [7:0] pkt[$];
   int  bytes_accepted = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_rsp = 1'b0;

   dns_query_question_parser_core #(.NAME_CAPACITY(NAME_CAP)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_byte_value(req_byte_value),
      .req_end_of_packet(req_end_of_packet),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_is_summary(rsp_is_summary),
      .rsp_name_char(rsp_name_char),
      .rsp_status(rsp_status),
      .rsp_query_id(rsp_query_id),
      .rsp_query_type(rsp_query_type),
      .rsp_query_class(rsp_query_class),
      .rsp_name_length(rsp_name_length)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.is_summary = rsp_is_summary;
         got.name_char = rsp_name_char;
         got.status = rsp_status;
         got.query_id = rsp_query_id;
         got.query_type = rsp_query_type;
         got.query_class = rsp_query_class;
         got.name_length = rsp_name_length;
         board.check_result(got);
      end
   end

   // One long receiver hold-off early on, so the result queue fills and the
   // parser has to stall the byte stream.
   initial begin
      while (bytes_accepted < HOLD_AFTER) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 4))
         0: return UPPER_A + 8'($urandom_range(0, 25));
         1: return "a" + 8'($urandom_range(0, 25));
         2: return "0" + 8'($urandom_range(0, 9));
         3: return "-";
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic int pick_label_len();
      case ($urandom_range(0, 9))
         0: return MAX_LABEL - 1;
         1: return 1;
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   function automatic void push_random(int n);
      repeat (n) pkt.push_back(8'($urandom));
   endfunction

   function automatic void push_label(int len);
      pkt.push_back(8'(len));
      repeat (len) pkt.push_back(pick_char());
   endfunction

   function automatic void push_header(logic [15:0] cnt);
      logic [15:0] id;
      id = 16'($urandom);
      pkt.push_back(id[15:8]);
      pkt.push_back(id[7:0]);
      push_random(2);
      pkt.push_back(cnt[15:8]);
      pkt.push_back(cnt[7:0]);
      push_random(HEADER_BYTES - 6);
   endfunction

   function automatic void push_name(int labels);
      repeat (labels) push_label(pick_label_len());
   endfunction

   // Half are well-formed questions with random content; most of the rest break one rule.
   function automatic void build_packet();
      int          kind, len, choice;
      logic [15:0] cnt;
      kind = $urandom_range(0, 99);
      pkt.delete();
      if (kind < 50) begin
         push_header(16'd1);
         push_name($urandom_range(0, 4));
         pkt.push_back(CHAR_NUL);
         push_random(TAIL_BYTES);
         if ($urandom_range(0, 3) == 0) push_random($urandom_range(1, 3));
      end else if (kind < 55) begin
         push_header(16'($urandom));
         len = $urandom_range(1, HEADER_BYTES);
         while (pkt.size() > len) void'(pkt.pop_back());
      end else if (kind < 60) begin
         case ($urandom_range(0, 3))
            0: cnt = 16'h0000;
            1: cnt = 16'h0100;
            2: cnt = 16'hFFFF;
            default: cnt = 16'($urandom);
         endcase
         if (cnt == 16'd1) cnt = 16'd2;
         push_header(cnt);
         push_name($urandom_range(0, 2));
         pkt.push_back(CHAR_NUL);
         push_random(TAIL_BYTES);
      end else if (kind < 65) begin
         push_header(16'd1);
         push_name($urandom_range(0, 3));
      end else if (kind < 70) begin
         push_header(16'd1);
         push_name($urandom_range(0, 2));
         pkt.push_back(8'($urandom_range(MAX_LABEL, 255)));
         push_random($urandom_range(0, 4));
      end else if (kind < 75) begin
         push_header(16'd1);
         push_name($urandom_range(0, 2));
         len = pick_label_len();
         pkt.push_back(8'(len));
         repeat ($urandom_range(0, len - 1)) pkt.push_back(pick_char());
      end else if (kind < 80) begin
         push_header(16'd1);
         push_name($urandom_range(0, 3));
         pkt.push_back(CHAR_NUL);
         push_random($urandom_range(0, TAIL_BYTES - 1));
      end else if (kind < 82) begin
         // Names that end at or run past the capacity of the name buffer.
         push_header(16'd1);
         repeat (3) push_label(MAX_LABEL - 1);
         push_label($urandom_range(55, MAX_LABEL - 1));
         choice = $urandom_range(0, 2);
         if (choice != 0) begin
            len = $urandom_range(1, 5);
            pkt.push_back(8'(len));
            repeat ((choice == 1) ? len : $urandom_range(0, len - 1))
               pkt.push_back(pick_char());
         end
         if (choice != 2) begin
            pkt.push_back(CHAR_NUL);
            push_random(TAIL_BYTES);
         end
      end else if (kind < 90) begin
         push_header(16'd1);
         push_name($urandom_range(1, 3));
         pkt.push_back(CHAR_NUL);
         push_random(TAIL_BYTES);
         pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
      end else begin
         push_random($urandom_range(1, 24));
      end
   endfunction

   // Entered and left at a falling edge.
   task automatic send_byte(logic [7:0] b, logic eop);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= b;
      req_end_of_packet <= eop;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(b, eop);
      bytes_accepted++;
      @(negedge clock);
   endtask

   task automatic send_packet();
      foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A lone byte, then a short question with letters at both ends of the alphabet
      // and the characters just outside it.
      pkt = '{8'hFF};
      send_packet();
      pkt = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'hFF, 8'hFF, 8'h04, "A", "Z", "@", "[", CHAR_NUL,
              8'hFF, 8'hFF, 8'h00, 8'h00};
      send_packet();

      for (int stage = 0; stage < 4; stage++) begin
         case (stage)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         while (bytes_accepted < (stage + 1) * STAGE_BYTES) begin
            build_packet();
            send_packet();
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/dqp_pkg.sv
rtl/dqp_out_queue.sv
rtl/dns_query_question_parser_core.sv
tb/testbench.sv
